FILE: rtl/tnlc_pkg.sv
// ----------------------------------------------------------------------------
// tnlc_pkg
// Shared types and codes for the negative lookup cache.
// ----------------------------------------------------------------------------
package tnlc_pkg;

  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [0:0] REG_TTL = 1'b0;
  localparam logic [0:0] REG_CAP = 1'b1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] key;
    logic [31:0] now_ms;
  } tnlc_req_t;

endpackage

FILE: rtl/tnlc_front.sv
// ----------------------------------------------------------------------------
// tnlc_front
// Accepts requests, masks the key and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module tnlc_front
  import tnlc_pkg::*;
#(
  parameter int KEY_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [63:0] in_key,
  input  logic [31:0] in_now_ms,
  output logic        q_valid,
  output tnlc_req_t   q_req,
  input  logic        q_take
);

  tnlc_req_t  slot_r [2];
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  tnlc_req_t  req;
  logic [63:0] mask;

  assign mask = {64{1'b1}} >> (64 - KEY_BITS);
  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign q_req = slot_r[rd_r];

  always_comb begin
    req.cmd = in_cmd;
    req.key = in_key & mask;
    req.now_ms = in_now_ms;
    rd_nxt = rd_r ^ q_take;
    wr_nxt = wr_r ^ push;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 1'b0;
      wr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r <= rd_nxt;
      wr_r <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) slot_r[wr_r] <= req;
  end

endmodule

FILE: rtl/tnlc_back.sv
// ----------------------------------------------------------------------------
// tnlc_back
// Scans the table one entry a cycle and carries out each request.
// ----------------------------------------------------------------------------
module tnlc_back
  import tnlc_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  tnlc_req_t   q_req,
  output logic        q_take,
  input  logic [31:0] ttl_ms,
  input  logic [4:0]  capacity,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_known_miss,
  output logic        out_evicted,
  output logic [4:0]  out_entry_count
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FIND  = 6'b000010,
    S_EXP   = 6'b000100,
    S_OLD   = 6'b001000,
    S_APPLY = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t          st_r;
  tnlc_req_t       req_r;
  logic [63:0]     keys_r  [ENTRIES];
  logic [31:0]     stamp_r [ENTRIES];
  logic [IW-1:0]   rank_r  [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic [CW-1:0]   count_r;
  logic [IW:0]     idx_r;
  logic            hit_r;
  logic [IW-1:0]   hit_idx_r;
  logic            old_r;
  logic [IW-1:0]   old_idx_r;
  logic            known_r, evict_r;
  logic [IW-1:0]   cur;
  logic [CW-1:0]   cap;
  logic            last;
  logic            cur_exp;
  logic [IW-1:0]   free_idx;
  logic            free_ok;

  assign cur = idx_r[IW-1:0];
  assign last = (idx_r == (IW+1)'(ENTRIES - 1));
  assign cur_exp = (req_r.now_ms - stamp_r[cur]) > ttl_ms;
  assign q_take = (st_r == S_IDLE) && q_valid;
  assign out_valid = (st_r == S_OUT);
  assign out_known_miss = known_r;
  assign out_evicted = evict_r;
  assign out_entry_count = 5'(count_r);

  always_comb begin
    if (capacity == 5'd0) cap = CW'(1);
    else if ({27'd0, capacity} > ENTRIES) cap = CW'(ENTRIES);
    else cap = CW'(capacity);
  end

  always_comb begin
    free_ok = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_ok = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      valid_r <= '0;
      count_r <= '0;
    end else begin
      unique case (st_r)
        S_IDLE: if (q_valid) begin
          req_r <= q_req;
          idx_r <= '0;
          hit_r <= 1'b0;
          old_r <= 1'b0;
          known_r <= 1'b0;
          evict_r <= 1'b0;
          if (q_req.cmd == CMD_CLEAR) begin
            valid_r <= '0;
            count_r <= '0;
            st_r <= S_OUT;
          end else if (q_req.cmd == CMD_RECORD || q_req.cmd == CMD_QUERY) begin
            st_r <= S_FIND;
          end else begin
            st_r <= S_OUT;
          end
        end
        S_FIND: begin
          if (valid_r[cur] && keys_r[cur] == req_r.key && !hit_r) begin
            hit_r <= 1'b1;
            hit_idx_r <= cur;
          end
          if (last) begin
            idx_r <= '0;
            if (req_r.cmd == CMD_RECORD && count_r >= cap && !(hit_r ||
                (valid_r[cur] && keys_r[cur] == req_r.key)))
              st_r <= S_EXP;
            else
              st_r <= S_APPLY;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_EXP: begin
          if (valid_r[cur] && cur_exp) begin
            valid_r[cur] <= 1'b0;
            count_r <= count_r - 1'b1;
            for (int j = 0; j < ENTRIES; j++)
              if (valid_r[j] && rank_r[j] > rank_r[cur]) rank_r[j] <= rank_r[j] - 1'b1;
          end
          if (last) begin
            idx_r <= '0;
            st_r <= S_OLD;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_OLD: begin
          if (count_r >= cap && count_r != '0 && valid_r[cur] &&
              CW'(rank_r[cur]) == count_r - 1'b1) begin
            old_r <= 1'b1;
            old_idx_r <= cur;
          end
          idx_r <= idx_r + 1'b1;
          if (last) st_r <= S_APPLY;
        end
        S_APPLY: begin
          st_r <= S_OUT;
          if (req_r.cmd == CMD_QUERY) begin
            if (hit_r) begin
              if ((req_r.now_ms - stamp_r[hit_idx_r]) > ttl_ms) begin
                valid_r[hit_idx_r] <= 1'b0;
                count_r <= count_r - 1'b1;
                for (int j = 0; j < ENTRIES; j++)
                  if (valid_r[j] && rank_r[j] > rank_r[hit_idx_r])
                    rank_r[j] <= rank_r[j] - 1'b1;
              end else known_r <= 1'b1;
            end
          end else if (hit_r) begin
            stamp_r[hit_idx_r] <= req_r.now_ms;
            for (int j = 0; j < ENTRIES; j++)
              if (valid_r[j] && rank_r[j] < rank_r[hit_idx_r]) rank_r[j] <= rank_r[j] + 1'b1;
            rank_r[hit_idx_r] <= '0;
          end else if (old_r) begin
            // Oldest entry goes; key fills lowest free slot, at rank zero.
            evict_r <= 1'b1;
            begin
              logic [IW-1:0] slot;
              logic [ENTRIES-1:0] v;
              slot = free_idx;
              v = valid_r;
              v[old_idx_r] = 1'b0;
              if (!free_ok || old_idx_r < free_idx) slot = old_idx_r;
              keys_r[slot] <= req_r.key;
              stamp_r[slot] <= req_r.now_ms;
              valid_r <= v | (ENTRIES'(1) << slot);
              for (int j = 0; j < ENTRIES; j++)
                if (v[j]) rank_r[j] <= rank_r[j] + 1'b1;
              rank_r[slot] <= '0;
            end
          end else if (free_ok) begin
            keys_r[free_idx] <= req_r.key;
            stamp_r[free_idx] <= req_r.now_ms;
            valid_r[free_idx] <= 1'b1;
            count_r <= count_r + 1'b1;
            for (int j = 0; j < ENTRIES; j++)
              if (valid_r[j]) rank_r[j] <= rank_r[j] + 1'b1;
            rank_r[free_idx] <= '0;
          end
        end
        S_OUT: if (!out_stall) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/ttl_negative_lookup_cache_unit.sv
// ----------------------------------------------------------------------------
// ttl_negative_lookup_cache_unit
// Negative lookup cache with time-to-live expiry and oldest-entry eviction.
// ----------------------------------------------------------------------------
// A query, or a record that needs no eviction, runs the key search scan and
// then the apply step before its result; a record of a new key into a table
// at capacity also runs the expiry sweep and the oldest-entry search. A
// clear or an unused command goes straight to the result. The table scan in
// the back end visits one entry a cycle for the key search, the expiry sweep
// and the oldest-entry search. Up to two requests wait in the front queue
// while a result is held.
module ttl_negative_lookup_cache_unit
  import tnlc_pkg::*;
#(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [63:0] in_key,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_known_miss,
  output logic        out_evicted,
  output logic [4:0]  out_entry_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] ttl_r;
  logic [4:0]  cap_r;
  logic        q_valid, q_take;
  tnlc_req_t   q_req;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAP) ? {27'd0, cap_r} : ttl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r <= 32'd60000;
      cap_r <= 5'd16;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_TTL) ttl_r <= pwdata;
      else cap_r <= pwdata[4:0];
    end
  end

  tnlc_front #(.KEY_BITS(KEY_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_cmd, .in_key, .in_now_ms,
    .q_valid, .q_req, .q_take
  );

  tnlc_back #(.ENTRIES(ENTRIES)) u_back (
    .clk, .rst_n, .q_valid, .q_req, .q_take,
    .ttl_ms(ttl_r), .capacity(cap_r),
    .out_valid, .out_stall, .out_known_miss, .out_evicted, .out_entry_count
  );

endmodule

FILE: rtl/tnlc_checker.sv
// ----------------------------------------------------------------------------
// tnlc_checker
// Port-level checks of the negative lookup cache.
// ----------------------------------------------------------------------------
module tnlc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_known_miss,
  input logic       out_evicted,
  input logic [4:0] out_entry_count
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_entry_count))
    else $error("Stalled result changed.");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_known_miss && out_evicted))
    else $error("Query hit and eviction in one result.");

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_known_miss |-> out_entry_count != 5'd0)
    else $error("Hit reported on an empty table.");

  a_ev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> out_entry_count != 5'd0)
    else $error("Eviction left an empty table.");

endmodule

bind ttl_negative_lookup_cache_unit tnlc_checker u_tnlc_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_known_miss, .out_evicted,
  .out_entry_count
);
